### sv/assert_macros.svh
// Assertion macros shared by the RTL of the frame luma average block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/fla_pkg.sv
// Shared types and constants of the frame luma average block.
// No dependencies; used by the interfaces, controller, datapath and top level.
package fla_pkg;

	localparam int PIX_W      = 8;
	localparam int DIM_W      = 13;
	localparam int AREA_W     = 2 * DIM_W;
	localparam int FSUM_W     = 32;
	localparam int ASUM_W     = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int DIV_CNT_W  = 4;

	// Rec.709 weights in 16-bit fixed point; they sum to exactly 65536.
	localparam logic [15:0] WEIGHT_B = 16'd4732;
	localparam logic [15:0] WEIGHT_G = 16'd46871;
	localparam logic [15:0] WEIGHT_R = 16'd13933;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LUMA_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	// Luma modes.
	localparam logic MODE_WEIGHTED = 1'b0;
	localparam logic MODE_VALUE    = 1'b1;

	// The divider runs one saturation check and then eight quotient bits.
	localparam logic [DIV_CNT_W-1:0] DIV_FIRST = 4'd8;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 4'd0;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
		logic             last_in_frame;
		logic             last_in_video;
	} pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic             luma_valid;
		logic [PIX_W-1:0] frame_avg;
		logic             frame_avg_valid;
		logic [PIX_W-1:0] video_avg;
		logic             video_avg_valid;
	} res_t;

	typedef struct packed {
		logic             luma_mode;
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
	} cfg_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic accum;
		logic div_load_frame;
		logic div_load_video;
		logic div_step;
		logic frame_update;
		logic video_finish;
		logic push;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic counted;
		logic frame_end;
		logic video_end;
		logic div_last;
	} status_t;

endpackage

### sv/fla_if.sv
// Request channel interfaces of the frame luma average block.
// Depends on fla_pkg for the pixel and result payload types.
interface fla_pix_if import fla_pkg::*; ();
	logic valid;
	logic ready;
	pix_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface fla_res_if import fla_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### sv/fla_ctrl.sv
// Sequencing state machine of the frame luma average block.
// Depends on fla_pkg for the command and status structs.
module fla_ctrl import fla_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_FDIV,
		ST_FUPD,
		ST_VLOAD,
		ST_VDIV,
		ST_VFIN,
		ST_PUSH
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				if (st.frame_end && st.counted) begin
					cmd.div_load_frame = 1'b1;
					state_nxt          = ST_FDIV;
				end else if (st.video_end) begin
					state_nxt = ST_VLOAD;
				end else begin
					state_nxt = ST_PUSH;
				end
			end
			ST_FDIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_nxt = ST_FUPD;
				end
			end
			ST_FUPD: begin
				cmd.frame_update = 1'b1;
				state_nxt        = st.video_end ? ST_VLOAD : ST_PUSH;
			end
			ST_VLOAD: begin
				cmd.div_load_video = 1'b1;
				state_nxt          = ST_VDIV;
			end
			ST_VDIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_nxt = ST_VFIN;
				end
			end
			ST_VFIN: begin
				cmd.video_finish = 1'b1;
				state_nxt        = ST_PUSH;
			end
			ST_PUSH: begin
				if (slot_free) begin
					cmd.push  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### sv/fla_dp.sv
// Datapath of the frame luma average block: luma, sums, shared divider, result register.
// Depends on fla_pkg; driven by commands from fla_ctrl.
module fla_dp import fla_pkg::*; #(
	parameter int MAX_FRAMES = 65536
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  pix_t    pix_data,
	input  cmd_t    cmd,
	output status_t st,
	output res_t    res_data
);

	localparam int CW   = $clog2(MAX_FRAMES + 1);
	localparam int DIVW = (CW > AREA_W) ? CW : AREA_W;
	localparam int DSW  = DIVW + PIX_W;

	// Pixel luma, computed from the incoming request.
	logic [23:0]      wsum;
	logic [PIX_W-1:0] vmax;
	logic [PIX_W-1:0] luma_calc;
	logic             counted_calc;

	// Captured request.
	logic [PIX_W-1:0] luma_q;
	logic             counted_q;
	logic             fend_q;
	logic             vend_q;

	// Running statistics.
	logic [AREA_W-1:0] area_q;
	logic [FSUM_W-1:0] fsum_q;
	logic [ASUM_W-1:0] asum_q;
	logic [CW-1:0]     count_q;
	logic [FSUM_W:0]   fsum_ext;
	logic [FSUM_W-1:0] fsum_next;
	logic [ASUM_W:0]   asum_ext;

	// Shared restoring divider.
	logic [FSUM_W-1:0]    rem_q;
	logic [DSW-1:0]       dsh_q;
	logic [PIX_W-1:0]     quo_q;
	logic                 sat_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 ge;
	logic [PIX_W-1:0]     div_res;

	// Result fields.
	logic [PIX_W-1:0] favg_q;
	logic             favg_valid_q;
	logic [PIX_W-1:0] vavg_q;
	res_t             res_q;

	always_comb begin
		wsum = 24'(WEIGHT_B) * 24'(pix_data.blue) + 24'(WEIGHT_G) * 24'(pix_data.green)
			+ 24'(WEIGHT_R) * 24'(pix_data.red);
		vmax = pix_data.blue;
		if (pix_data.green > vmax) begin
			vmax = pix_data.green;
		end
		if (pix_data.red > vmax) begin
			vmax = pix_data.red;
		end
	end

	assign luma_calc    = (cfg.luma_mode == MODE_VALUE) ? vmax : wsum[23:16];
	assign counted_calc = (cfg.frame_width > DIM_W'(1)) && (cfg.frame_height > DIM_W'(1));

	assign fsum_ext  = {1'b0, fsum_q} + (FSUM_W + 1)'(luma_q);
	assign fsum_next = fsum_ext[FSUM_W] ? '1 : fsum_ext[FSUM_W-1:0];
	assign asum_ext  = {1'b0, asum_q} + (ASUM_W + 1)'(div_res);

	assign ge      = {{(DSW - FSUM_W){1'b0}}, rem_q} >= dsh_q;
	assign div_res = sat_q ? '1 : quo_q;

	assign st.counted   = counted_q;
	assign st.frame_end = fend_q;
	assign st.video_end = vend_q;
	assign st.div_last  = (cnt_q == DIV_LAST);

	assign res_data = res_q;

	// Registered area; users must change configuration only while idle (not enforced).
	always_ff @(posedge clk) begin
		area_q <= AREA_W'(cfg.frame_width) * AREA_W'(cfg.frame_height);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			luma_q    <= counted_calc ? luma_calc : '0;
			counted_q <= counted_calc;
			fend_q    <= pix_data.last_in_frame || pix_data.last_in_video;
			vend_q    <= pix_data.last_in_video;
		end
		if (cmd.push) begin
			res_q.luma            <= luma_q;
			res_q.luma_valid      <= counted_q;
			res_q.frame_avg       <= favg_q;
			res_q.frame_avg_valid <= favg_valid_q;
			res_q.video_avg       <= vavg_q;
			res_q.video_avg_valid <= vend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsum_q       <= '0;
			asum_q       <= '0;
			count_q      <= '0;
			favg_q       <= '0;
			favg_valid_q <= 1'b0;
			vavg_q       <= '0;
		end else begin
			if (cmd.capture) begin
				favg_q       <= '0;
				favg_valid_q <= 1'b0;
				vavg_q       <= '0;
			end
			if (cmd.accum) begin
				// A skipped frame still drops whatever was summed before it ended.
				fsum_q <= (fend_q && !counted_q) ? '0 : fsum_next;
			end
			if (cmd.frame_update) begin
				favg_q       <= div_res;
				favg_valid_q <= 1'b1;
				fsum_q       <= '0;
				if (count_q < CW'(MAX_FRAMES)) begin
					count_q <= count_q + CW'(1);
					asum_q  <= asum_ext[ASUM_W] ? '1 : asum_ext[ASUM_W-1:0];
				end
			end
			if (cmd.video_finish) begin
				vavg_q  <= (count_q == '0) ? '0 : div_res;
				fsum_q  <= '0;
				asum_q  <= '0;
				count_q <= '0;
			end
		end
	end

	// The first step only checks for a quotient of 256 or more; the next eight
	// produce the quotient bits from the top down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= DIV_LAST;
		end else if (cmd.div_load_frame || cmd.div_load_video) begin
			cnt_q <= DIV_FIRST;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load_frame) begin
			rem_q <= fsum_next;
			dsh_q <= {DIVW'(area_q), {PIX_W{1'b0}}};
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.div_load_video) begin
			rem_q <= FSUM_W'(asum_q);
			dsh_q <= {DIVW'(count_q), {PIX_W{1'b0}}};
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.div_step) begin
			dsh_q <= dsh_q >> 1;
			if (cnt_q == DIV_FIRST) begin
				sat_q <= ge;
			end else begin
				quo_q <= {quo_q[PIX_W-2:0], ge};
				if (ge) begin
					rem_q <= rem_q - dsh_q[FSUM_W-1:0];
				end
			end
		end
	end

endmodule

### sv/frame_luma_average.sv
// Pixel requests are taken only while the block is idle, so a new pixel waits until the
// last one is through; a counted frame end adds a pass of the nine-step shared divider,
// and every video end adds one more pass of it, for the video average.
// Reset (arst_n low, asynchronous) clears all sums and the frame count and loads
// luma_mode 0, frame_width 640 and frame_height 480; no clearing pass is needed.
`include "assert_macros.svh"

module frame_luma_average import fla_pkg::*; #(
	parameter int MAX_FRAMES = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	fla_pix_if.sink               pix,
	fla_res_if.source             res
);

	// The block handles one pixel request at a time. The controller walks each request
	// through capture, accumulation and, at frame or video end, one or two passes of a
	// shared restoring divider; the datapath holds the luma logic, the running sums
	// and the result register. A finished result waits in that register, so the next
	// pixel is accepted while the sink is still stalled.

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t st;

	// Configuration registers. Writes are expected only while the block is idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.luma_mode    <= MODE_WEIGHTED;
			cfg_q.frame_width  <= FRAME_WIDTH_RST;
			cfg_q.frame_height <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LUMA_MODE:    cfg_q.luma_mode    <= cfg_data[0];
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: it decides which step runs in each cycle and owns both handshakes.
	fla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_ready  (pix.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath: the frame area is a registered 13 by 13 product, and both averages use
	// the same divider, which first tests for saturation at 255 and then resolves eight
	// quotient bits, one per cycle.
	fla_dp #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pix_data (pix.data),
		.cmd      (cmd),
		.st       (st),
		.res_data (res.data)
	);

	// Only one request is in flight, so an accepted pixel always closes the input.
	`ASSERT_CLKD(a_one_in_flight, clk, arst_n, (pix.valid && pix.ready) |=> !pix.ready, "pixel accepted while another is in flight")
	// A frame average is only given for a frame that is counted.
	`ASSERT_NEVER(a_favg_counted, clk, arst_n, res.valid && res.data.frame_avg_valid && !res.data.luma_valid, "frame average on a skipped frame")
	// The video average reads zero unless the result closes the video.
	`ASSERT_NEVER(a_vavg_zero, clk, arst_n, res.valid && !res.data.video_avg_valid && (res.data.video_avg != '0), "video average outside video end")

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for frame_luma_average: directed and random pixel streams.
// Depends on fla_pkg and the fla_pix_if / fla_res_if request channel interfaces.
module tb import fla_pkg::*; ();

	localparam int FRAME_LIMIT   = 65536;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PIXELS = 1350;
	localparam int SETTLE_CYCLES = 30;
	localparam int LONG_HOLD     = 400;
	localparam int MAX_GAP       = 18;

	// Rec.709 luma weights in 16-bit fixed point, kept here for the predictor.
	localparam logic [31:0] BLUE_SHARE  = 32'd4732;
	localparam logic [31:0] GREEN_SHARE = 32'd46871;
	localparam logic [31:0] RED_SHARE   = 32'd13933;

	// The tracker mirrors the registers and the running sums of the block, turns
	// every accepted pixel request into the result it must produce, and compares
	// the results that come back in order.
	class luma_tracker;
		logic             mode;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [31:0]      luma_sum;
		logic [23:0]      avg_sum;
		logic [16:0]      frame_count;
		res_t             awaited[$];
		int               mismatches;
		int               results_checked;
		int               frame_avgs_seen;
		int               video_avgs_seen;

		function new();
			mode            = MODE_WEIGHTED;
			width           = FRAME_WIDTH_RST;
			height          = FRAME_HEIGHT_RST;
			luma_sum        = '0;
			avg_sum         = '0;
			frame_count     = '0;
			mismatches      = 0;
			results_checked = 0;
			frame_avgs_seen = 0;
			video_avgs_seen = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_LUMA_MODE:    mode = data[0];
				REG_FRAME_WIDTH:  width = data;
				REG_FRAME_HEIGHT: height = data;
				default: ;
			endcase
		endfunction

		function logic [PIX_W-1:0] pixel_luma(pix_t p);
			logic [31:0]      weighted;
			logic [PIX_W-1:0] top;
			if (mode == MODE_WEIGHTED) begin
				weighted = BLUE_SHARE * 32'(p.blue) + GREEN_SHARE * 32'(p.green)
					+ RED_SHARE * 32'(p.red);
				return weighted[23:16];
			end
			top = p.blue;
			if (p.green > top) top = p.green;
			if (p.red > top) top = p.red;
			return top;
		endfunction

		function res_t predict_luma_result(pix_t p);
			res_t              r;
			logic              counted;
			logic              frame_end;
			logic [PIX_W-1:0]  luma;
			logic [AREA_W-1:0] area;
			logic [31:0]       quotient;
			logic [24:0]       wide_sum;
			r         = '0;
			counted   = (width > 1) && (height > 1);
			frame_end = p.last_in_frame || p.last_in_video;
			if (counted) begin
				luma         = pixel_luma(p);
				r.luma       = luma;
				r.luma_valid = 1'b1;
				if (luma_sum > 32'hFFFF_FFFF - 32'(luma)) luma_sum = '1;
				else luma_sum = luma_sum + 32'(luma);
			end
			if (frame_end) begin
				if (counted) begin
					area              = AREA_W'(width) * AREA_W'(height);
					quotient          = luma_sum / 32'(area);
					r.frame_avg       = (quotient > 255) ? 8'hFF : quotient[7:0];
					r.frame_avg_valid = 1'b1;
					if (frame_count < FRAME_LIMIT) begin
						frame_count = frame_count + 17'd1;
						wide_sum    = 25'(avg_sum) + 25'(r.frame_avg);
						avg_sum     = (wide_sum > 25'hFF_FFFF) ? 24'hFF_FFFF : wide_sum[23:0];
					end
				end
				luma_sum = '0;
			end
			if (p.last_in_video) begin
				r.video_avg_valid = 1'b1;
				if (frame_count != 0) begin
					quotient    = 32'(avg_sum) / 32'(frame_count);
					r.video_avg = (quotient > 255) ? 8'hFF : quotient[7:0];
				end
				luma_sum    = '0;
				avg_sum     = '0;
				frame_count = '0;
			end
			return r;
		endfunction

		function void note_pixel(pix_t p);
			awaited.insert(awaited.size(), predict_luma_result(p));
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 40) $display("mismatch at result %0d: %s", results_checked, what);
		endtask

		task check_result(res_t got);
			res_t want;
			results_checked++;
			if (awaited.size() == 0) begin
				report_mismatch("result arrived with no pixel request waiting for it");
				return;
			end
			want = awaited.pop_front();
			if (want.frame_avg_valid) frame_avgs_seen++;
			if (want.video_avg_valid) video_avgs_seen++;
			if (got.luma !== want.luma)
				report_mismatch($sformatf("luma %0d, expected %0d", got.luma, want.luma));
			if (got.luma_valid !== want.luma_valid)
				report_mismatch($sformatf("luma_valid %b, expected %b",
					got.luma_valid, want.luma_valid));
			if (got.frame_avg !== want.frame_avg)
				report_mismatch($sformatf("frame_avg %0d, expected %0d",
					got.frame_avg, want.frame_avg));
			if (got.frame_avg_valid !== want.frame_avg_valid)
				report_mismatch($sformatf("frame_avg_valid %b, expected %b",
					got.frame_avg_valid, want.frame_avg_valid));
			if (got.video_avg !== want.video_avg)
				report_mismatch($sformatf("video_avg %0d, expected %0d",
					got.video_avg, want.video_avg));
			if (got.video_avg_valid !== want.video_avg_valid)
				report_mismatch($sformatf("video_avg_valid %b, expected %b",
					got.video_avg_valid, want.video_avg_valid));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fla_pix_if pix_bus();
	fla_res_if res_bus();

	luma_tracker tracker;

	int cycle_count;
	int rx_hold_len;
	int pixels_sent;
	int videos_sent;
	int config_writes;
	bit offering;    // a pixel request is currently held on the input channel
	bit tx_quiet;    // the sender offers back to back, without gaps

	frame_luma_average #(
		.MAX_FRAMES(FRAME_LIMIT)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix      (pix_bus),
		.res      (res_bus)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// Result side. Before each result the sink draws a stall of random length,
	// except in quiet stretches where it keeps ready high. When the stimulus asks
	// for a long hold, the sink keeps ready low for that many cycles, counted here,
	// so the block backs up and has to stall its pixel input.
	initial begin : result_sink
		int stall;
		int run_left;
		bit rx_quiet;
		res_bus.ready <= 1'b0;
		run_left = 0;
		rx_quiet = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (run_left == 0) begin
				rx_quiet = ($urandom_range(0, 3) == 0);
				run_left = $urandom_range(20, 80);
			end
			run_left--;
			stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (rx_hold_len > 0) begin
				stall       = rx_hold_len;
				rx_hold_len = 0;
			end
			if (stall > 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (res_bus.valid !== 1'b1);
			tracker.check_result(res_bus.data);
		end
	end

	function automatic pix_t pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
			logic [PIX_W-1:0] r, logic frame_last, logic video_last);
		pix_t p;
		p.blue          = b;
		p.green         = g;
		p.red           = r;
		p.last_in_frame = frame_last;
		p.last_in_video = video_last;
		return p;
	endfunction

	// Components lean toward the extremes now and then so that black, white and
	// pure primaries show up often.
	function automatic logic [PIX_W-1:0] random_component();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pix_t random_pixel(logic frame_last, logic video_last);
		return pixel(random_component(), random_component(), random_component(),
			frame_last, video_last);
	endfunction

	// Offers one pixel request and returns once it is accepted. The valid line is
	// lowered only when a gap is drawn, so back-to-back requests keep it high.
	task automatic send_pixel(input pix_t p);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			if (offering) pix_bus.valid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.data  <= p;
		offering = 1'b1;
		do @(posedge clk); while (pix_bus.ready !== 1'b1);
		tracker.note_pixel(p);
		pixels_sent++;
	endtask

	// Stops offering and waits until every predicted result has come back, at
	// which point the block holds no work.
	task automatic drain_results();
		if (offering) pix_bus.valid <= 1'b0;
		offering = 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		tracker.set_register(index, data);
	endtask

	// Registers change only with the block idle. The mode word may carry junk in
	// its upper bits; only bit zero selects the mode.
	task automatic write_config(input logic [CFG_DATA_W-1:0] mode_data,
			input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		drain_results();
		cfg_we <= 1'b1;
		write_register(REG_LUMA_MODE, mode_data);
		write_register(REG_FRAME_WIDTH, w);
		write_register(REG_FRAME_HEIGHT, h);
		cfg_we <= 1'b0;
		config_writes++;
	endtask

	// Mostly small frames so the averages are meaningful; now and then a
	// degenerate one-pixel dimension, a 4096 x 4096 frame, or anything in range.
	task automatic random_config();
		logic [DIM_W-1:0]      w;
		logic [DIM_W-1:0]      h;
		logic [CFG_DATA_W-1:0] mode_data;
		mode_data = CFG_DATA_W'($urandom_range(0, 8191));
		case ($urandom_range(0, 11))
			0: begin
				w = DIM_W'(1);
				h = DIM_W'($urandom_range(1, 4096));
			end
			1: begin
				w = DIM_W'($urandom_range(1, 4096));
				h = DIM_W'(1);
			end
			2: begin
				w = DIM_W'(4096);
				h = DIM_W'(4096);
			end
			3: begin
				w = DIM_W'(4096);
				h = DIM_W'($urandom_range(2, 3));
			end
			4: begin
				w = DIM_W'($urandom_range(1, 4096));
				h = DIM_W'($urandom_range(1, 4096));
			end
			default: begin
				w = DIM_W'($urandom_range(2, 4));
				h = DIM_W'($urandom_range(2, 4));
			end
		endcase
		write_config(mode_data, w, h);
	endtask

	// One video: a run of frames, small ones mostly exactly one frame area long,
	// some short or overlong, large ones cut short, with the odd stray frame or
	// video marker mixed in, closed by a pixel that carries the video end.
	task automatic run_video(input int min_frames);
		int frames;
		int len;
		int area;
		frames = $urandom_range(min_frames, min_frames + 5);
		for (int f = 0; f < frames; f++) begin
			// Settings may also change between frames of one video.
			if (min_frames == 0 && $urandom_range(0, 11) == 0) random_config();
			area = int'(tracker.width) * int'(tracker.height);
			if (area > 20) begin
				len = $urandom_range(1, 12);
			end else begin
				case ($urandom_range(0, 7))
					0: len = $urandom_range(1, area);
					1: len = area + $urandom_range(1, 6);
					default: len = area;
				endcase
			end
			for (int i = 0; i < len; i++)
				send_pixel(random_pixel(i == len - 1 || $urandom_range(0, 29) == 0,
					$urandom_range(0, 59) == 0));
		end
		send_pixel(random_pixel($urandom_range(0, 1) == 1, 1'b1));
		videos_sent++;
	endtask

	initial begin : stimulus
		int target;
		int hold_video;
		tracker = new();
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_LUMA_MODE;
		cfg_data      <= '0;
		pix_bus.valid <= 1'b0;
		pix_bus.data  <= '0;
		offering    = 1'b0;
		tx_quiet    = 1'b0;
		rx_hold_len = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings (640 x 480, weighted): a dark and a white pixel ending a
		// frame far too short to lift the average above zero.
		send_pixel(pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
		send_pixel(pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0));

		// Weighted mode with junk in the upper mode bits, 2 x 2 frames: each pure
		// primary, a full frame, then a video end that also closes the frame.
		write_config({12'hFFF, MODE_WEIGHTED}, 13'd2, 13'd2);
		send_pixel(pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b0));
		send_pixel(pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b0));
		send_pixel(pixel(8'd0, 8'd0, 8'd255, 1'b0, 1'b0));
		send_pixel(pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0));
		send_pixel(pixel(8'd128, 8'd64, 8'd32, 1'b0, 1'b1));

		// Value mode: the maximum of the three components. Five bright pixels in a
		// 2 x 2 frame push the frame average past 255, where it saturates.
		write_config({12'h555, MODE_VALUE}, 13'd2, 13'd2);
		send_pixel(pixel(8'd10, 8'd200, 8'd30, 1'b0, 1'b0));
		send_pixel(pixel(8'd255, 8'd1, 8'd2, 1'b0, 1'b0));
		send_pixel(pixel(8'd3, 8'd4, 8'd255, 1'b0, 1'b0));
		send_pixel(pixel(8'd255, 8'd9, 8'd9, 1'b0, 1'b0));
		send_pixel(pixel(8'd0, 8'd0, 8'd255, 1'b1, 1'b0));
		send_pixel(pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b1));

		// Skipped frames: width 1, then height 1. A video without a counted frame
		// reports an average of zero.
		write_config({12'h000, MODE_WEIGHTED}, 13'd1, 13'd4096);
		send_pixel(pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0));
		send_pixel(pixel(8'd7, 8'd7, 8'd7, 1'b1, 1'b0));
		send_pixel(pixel(8'd1, 8'd2, 8'd3, 1'b0, 1'b1));
		write_config({12'h000, MODE_VALUE}, 13'd4096, 13'd1);
		send_pixel(pixel(8'd200, 8'd100, 8'd50, 1'b0, 1'b1));

		// A 4096 x 4096 frame: two pixels leave the average at zero.
		write_config({12'h000, MODE_WEIGHTED}, 13'd4096, 13'd4096);
		send_pixel(pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0));
		send_pixel(pixel(8'd255, 8'd128, 8'd1, 1'b1, 1'b1));

		// Back-to-back single-pixel videos: each starts from cleared sums.
		write_config({12'h000, MODE_VALUE}, 13'd3, 13'd2);
		send_pixel(pixel(8'd50, 8'd60, 8'd70, 1'b0, 1'b1));
		send_pixel(pixel(8'd80, 8'd90, 8'd100, 1'b0, 1'b1));

		// Random videos. One of them runs against a long receiver hold with the
		// sender offering back to back, after a full drain of the block.
		target     = pixels_sent + RANDOM_PIXELS;
		hold_video = $urandom_range(3, 8);
		while (pixels_sent < target) begin
			if (videos_sent % 4 == 0 || $urandom_range(0, 2) == 0) random_config();
			tx_quiet = ($urandom_range(0, 3) == 0);
			if (videos_sent == hold_video) begin
				drain_results();
				rx_hold_len = LONG_HOLD;
				tx_quiet    = 1'b1;
				run_video(8);
			end else begin
				run_video(0);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.awaited.size() != 0)
			tracker.report_mismatch($sformatf("%0d predicted results never arrived",
				tracker.awaited.size()));
		$display("Sent %0d pixels in %0d random videos plus directed cases, %0d settings.",
			pixels_sent, videos_sent, config_writes);
		$display("Checked %0d results, %0d frame averages and %0d video averages.",
			tracker.results_checked, tracker.frame_avgs_seen, tracker.video_avgs_seen);
		if (tracker.mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/fla_pkg.sv
sv/fla_if.sv
sv/fla_ctrl.sv
sv/fla_dp.sv
sv/frame_luma_average.sv
test/tb.sv
